FILE: rtl/bec_pkg.sv
// ----------------------------------------------------------------------------
// Button event classifier package
// Shared constants, register indexes, press-state codes and the command and
// status types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bec_pkg;

    // Number of input lines and width of the hold timers.
    localparam int NUM_SOURCES = 5;
    localparam int HOLD_WIDTH  = 16;

    // Index width that addresses one source.
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    // Fixed field widths.
    localparam int SRC_W      = 3;
    localparam int MASK_W     = 5;
    localparam int HOLD_CFG_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_CFG_W-1:0] HOLD_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EV0_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EV1_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd5;

    // Button press states.
    localparam logic [1:0] PS_IDLE    = 2'd0;
    localparam logic [1:0] PS_PRESSED = 2'd1;
    localparam logic [1:0] PS_LONG    = 2'd2;

    // Event indexes.
    localparam logic EV_PRIMARY   = 1'b0;
    localparam logic EV_SECONDARY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_emit;
        logic out_free;
    } t_stat;

    // Bit of a per-source mask; sources beyond the mask read as zero.
    function automatic logic mask_bit(logic [MASK_W-1:0] m, logic [IDX_W-1:0] s);
        logic [MASK_W-1:0] t;
        t = m >> s;
        return t[0];
    endfunction

endpackage

FILE: rtl/button_event_classifier.sv
// ----------------------------------------------------------------------------
// Button event classifier
// Turns level changes on several input lines into click and hold events,
// with per-source inversion, button handling and long-press timers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, fields i_mode, i_source,
//   i_level) takes one item at a time: a level change of one source, or a
//   tick that counts down every armed hold timer.
//   Output channel (o_out_valid / i_out_stall) delivers zero or more events
//   per item; o_last marks the final event of an item. An item that yields no
//   event produces nothing on the output. Configuration channel
//   (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) writes the masks and
//   the hold length; the user writes only while the block idles, unenforced.
// Sequencing:
//   A level change is accepted, then takes one update step; a tick is
//   accepted, then the controller visits one source timer per cycle unless
//   stalled. An event shows on the output in the cycle after its step.
//   When the receiver stalls, a step that has an event to deliver waits
//   until the output register frees, and the input stays stalled.
// Reset: all buttons idle, timers disarmed, masks zero, hold length 1000.
// ----------------------------------------------------------------------------
module button_event_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [bec_pkg::SRC_W-1:0]      i_source,
    input  logic                           i_level,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bec_pkg::SRC_W-1:0]      o_event_source,
    output logic                           o_event_index,
    output logic                           o_last
);
    import bec_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer for items and timer walks.
    bec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // State, configuration and output register.
    bec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_source       (i_source),
        .i_level        (i_level),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_source (o_event_source),
        .o_event_index  (o_event_index),
        .o_last         (o_last)
    );

endmodule

FILE: rtl/bec_ctrl.sv
// ----------------------------------------------------------------------------
// Button event classifier controller
// Sequences one item at a time: a level change takes one step, a tick walks
// the hold timers one source per step. A step that produces an event waits
// until the output register is free.
// ----------------------------------------------------------------------------
module bec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_mode,
    output logic          o_in_stall,
    input  bec_pkg::t_stat i_stat,
    output bec_pkg::t_cmd  o_cmd
);
    import bec_pkg::*;

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_LEVEL = 2'd1;
    localparam logic [1:0] CS_SCAN  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             go;

    // A step may proceed when it emits nothing or the output can take it.
    assign go         = !i_stat.need_emit || i_stat.out_free;
    assign accept     = i_in_valid && (r_state == CS_IDLE);
    assign o_in_stall = (r_state != CS_IDLE);

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.idx  = r_idx;
        unique case (r_state)
            CS_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = i_mode ? CS_SCAN : CS_LEVEL;
                end
            end
            CS_LEVEL: begin
                if (go) begin
                    o_cmd.step = 1'b1;
                    n_state    = CS_IDLE;
                end
            end
            CS_SCAN: begin
                if (go) begin
                    o_cmd.step = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = CS_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: rtl/bec_dp.sv
// ----------------------------------------------------------------------------
// Button event classifier datapath
// Holds the configuration registers, the per-source press states and hold
// timers, the captured item and the output register.
// ----------------------------------------------------------------------------
module bec_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bec_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_mode,
    input  logic [bec_pkg::SRC_W-1:0]         i_source,
    input  logic                              i_level,
    input  bec_pkg::t_cmd                     i_cmd,
    output bec_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bec_pkg::SRC_W-1:0]         o_event_source,
    output logic                              o_event_index,
    output logic                              o_last
);
    import bec_pkg::*;

    localparam logic [32:0] HOLD_MAX = (33'd1 << HOLD_WIDTH) - 33'd1;

    // Configuration registers.
    logic [MASK_W-1:0]     r_inv, r_btn, r_lp, r_en0, r_en1;
    logic [HOLD_CFG_W-1:0] r_hold;

    // Per-source state.
    logic [1:0]            r_ps    [NUM_SOURCES];
    logic [HOLD_WIDTH-1:0] r_cnt   [NUM_SOURCES];
    logic                  r_armed [NUM_SOURCES];

    // Captured item.
    logic             r_mode;
    logic [SRC_W-1:0] r_src;
    logic             r_lvl;

    // Output register.
    logic             r_out_valid;
    logic [SRC_W-1:0] r_ev_src;
    logic             r_ev_idx;
    logic             r_last;

    logic [IDX_W-1:0]      addr;
    logic                  src_ok;
    logic [NUM_SOURCES-1:0] expire, emit_t, higher;
    logic                  lvl, btn, lp;
    logic [1:0]            ps, n_ps;
    logic                  armed, n_armed;
    logic [HOLD_WIDTH-1:0] cnt, n_cnt, hold_load;
    logic                  lev_emit, lev_idx, ev_en, need_emit, out_free;
    logic [HOLD_CFG_W-1:0] hold_nz;
    logic [32:0]           hold_ext;

    assign o_cfg_ready = 1'b1;

    // Timer load value: zero loads one, values too wide saturate.
    always_comb begin
        hold_nz  = (r_hold == '0) ? HOLD_CFG_W'(1) : r_hold;
        hold_ext = 33'(hold_nz);
        if (hold_ext > HOLD_MAX) begin
            hold_ext = HOLD_MAX;
        end
        hold_load = HOLD_WIDTH'(hold_ext);
    end

    // Expiry and tick events of every source, for the last-event flag.
    always_comb begin
        for (int s = 0; s < NUM_SOURCES; s++) begin
            expire[s] = r_armed[s] && (r_cnt[s] <= HOLD_WIDTH'(1));
            emit_t[s] = expire[s] && (r_ps[s] == PS_PRESSED)
                        && mask_bit(r_en1, IDX_W'(s));
            higher[s] = (s > int'(i_cmd.idx));
        end
    end

    // Step logic for the addressed source.
    always_comb begin
        addr     = r_mode ? i_cmd.idx : IDX_W'(r_src);
        src_ok   = r_mode || (int'(r_src) < NUM_SOURCES);
        ps       = r_ps[addr];
        cnt      = r_cnt[addr];
        armed    = r_armed[addr];
        lvl      = r_lvl ^ mask_bit(r_inv, addr);
        btn      = mask_bit(r_btn, addr);
        lp       = mask_bit(r_lp, addr);
        n_ps     = ps;
        n_cnt    = cnt;
        n_armed  = armed;
        lev_emit = 1'b0;
        lev_idx  = EV_PRIMARY;
        if (r_mode) begin
            // Tick: count down an armed timer and promote on expiry.
            if (armed) begin
                if (cnt != '0) begin
                    n_cnt = cnt - 1'b1;
                end
                if (expire[addr]) begin
                    n_armed = 1'b0;
                    if (ps == PS_PRESSED) begin
                        n_ps = PS_LONG;
                    end
                end
            end
        end else if (btn) begin
            if (lvl) begin
                // Press from idle: arm the timer unless armed, or click at once.
                if (ps == PS_IDLE) begin
                    n_ps = PS_PRESSED;
                    if (lp) begin
                        if (!armed) begin
                            n_armed = 1'b1;
                            n_cnt   = hold_load;
                        end
                    end else begin
                        lev_emit = 1'b1;
                        lev_idx  = EV_PRIMARY;
                    end
                end
            end else begin
                // Release: a short press reports its event.
                if (lp) begin
                    n_armed  = 1'b0;
                    n_cnt    = '0;
                    lev_emit = (ps == PS_PRESSED);
                    lev_idx  = EV_PRIMARY;
                end else begin
                    lev_emit = (ps == PS_PRESSED);
                    lev_idx  = EV_SECONDARY;
                end
                n_ps = PS_IDLE;
            end
        end else begin
            // Plain line: the event index follows the level.
            lev_emit = 1'b1;
            lev_idx  = lvl;
        end
        ev_en     = lev_idx ? mask_bit(r_en1, addr) : mask_bit(r_en0, addr);
        need_emit = r_mode ? emit_t[addr] : (src_ok && lev_emit && ev_en);
    end

    assign out_free         = !r_out_valid || !i_out_stall;
    assign o_stat.need_emit = need_emit;
    assign o_stat.out_free  = out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= '0;
            r_btn  <= '0;
            r_lp   <= '0;
            r_en0  <= '0;
            r_en1  <= '0;
            r_hold <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INVERT: r_inv  <= i_cfg_data[MASK_W-1:0];
                REG_BUTTON: r_btn  <= i_cfg_data[MASK_W-1:0];
                REG_LONG:   r_lp   <= i_cfg_data[MASK_W-1:0];
                REG_EV0_EN: r_en0  <= i_cfg_data[MASK_W-1:0];
                REG_EV1_EN: r_en1  <= i_cfg_data[MASK_W-1:0];
                REG_HOLD:   r_hold <= i_cfg_data[HOLD_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-source state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_ps[s]    <= PS_IDLE;
                r_cnt[s]   <= '0;
                r_armed[s] <= 1'b0;
            end
        end else if (i_cmd.step && src_ok) begin
            r_ps[addr]    <= n_ps;
            r_cnt[addr]   <= n_cnt;
            r_armed[addr] <= n_armed;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_src  <= i_source;
            r_lvl  <= i_level;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && need_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && need_emit) begin
            r_ev_src <= SRC_W'(addr);
            r_ev_idx <= r_mode ? EV_SECONDARY : lev_idx;
            r_last   <= r_mode ? !(|(emit_t & higher)) : 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_source = r_ev_src;
    assign o_event_index  = r_ev_idx;
    assign o_last         = r_last;

    // A step that emits never overwrites a result still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && need_emit) |-> out_free)
        else $error("event step issued while output register busy");

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid)
        else $error("output valid after reset");

    // A new item is never captured while a step is issued.
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.step))
        else $error("load and step in the same cycle");

    // An armed timer always holds a nonzero count.
    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed[addr] |-> (r_cnt[addr] != '0)))
        else $error("armed hold timer with zero count");

endmodule

FILE: tb/bec_tb_pkg.sv
// ----------------------------------------------------------------------------
// Button event classifier test package
// Item and event records, plus a tracker class that keeps its own copy of
// the masks, press states and hold timers, predicts the events that every
// accepted item causes, and checks delivered events in order.
// ----------------------------------------------------------------------------
package bec_tb_pkg;

    import bec_pkg::*;

    // Item modes.
    localparam logic MODE_LEVEL = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // First register index past the defined registers; writes there do nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_HOLD + 3'd1;

    // One input item.
    typedef struct packed {
        logic             mode;
        logic [SRC_W-1:0] source;
        logic             level;
    } t_line_item;

    // One delivered event.
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic             idx;
        logic             last;
    } t_event_rec;

    class bec_event_tracker;
        logic [MASK_W-1:0]     invert;
        logic [MASK_W-1:0]     button;
        logic [MASK_W-1:0]     long_press;
        logic [MASK_W-1:0]     ev0_en;
        logic [MASK_W-1:0]     ev1_en;
        logic [HOLD_CFG_W-1:0] hold_len;

        logic [1:0]            press[NUM_SOURCES];
        logic [HOLD_WIDTH-1:0] count[NUM_SOURCES];
        bit                    armed[NUM_SOURCES];

        // Events of the item being worked out, and events not yet delivered.
        t_event_rec            batch[$];
        t_event_rec            pending[$];

        int                    mismatches;
        int                    items_seen;
        int                    events_seen;

        function new();
            invert     = '0;
            button     = '0;
            long_press = '0;
            ev0_en     = '0;
            ev1_en     = '0;
            hold_len   = HOLD_RESET;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                press[s] = PS_IDLE;
                count[s] = '0;
                armed[s] = 1'b0;
            end
            mismatches  = 0;
            items_seen  = 0;
            events_seen = 0;
        endfunction

        // Register write; only the low bits of each register are kept.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INVERT: invert     = data[MASK_W-1:0];
                REG_BUTTON: button     = data[MASK_W-1:0];
                REG_LONG:   long_press = data[MASK_W-1:0];
                REG_EV0_EN: ev0_en     = data[MASK_W-1:0];
                REG_EV1_EN: ev1_en     = data[MASK_W-1:0];
                REG_HOLD:   hold_len   = data[HOLD_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Timer load value: zero loads one, and the load saturates at the timer width.
        function logic [HOLD_WIDTH-1:0] hold_load();
            longint unsigned v;
            v = (hold_len == 0) ? 1 : hold_len;
            if (v > (64'd1 << HOLD_WIDTH) - 1)
                v = (64'd1 << HOLD_WIDTH) - 1;
            return HOLD_WIDTH'(v);
        endfunction

        // Queue an event if its index is enabled for the source.
        function void emit(int s, logic ix);
            logic [MASK_W-1:0] en;
            t_event_rec        e;
            en = ix ? ev1_en : ev0_en;
            if (en[s] && batch.size() < NUM_SOURCES) begin
                e.src  = SRC_W'(s);
                e.idx  = ix;
                e.last = 1'b0;
                batch.push_back(e);
            end
        endfunction

        // Work out the events that one accepted item causes.
        function void note_item(t_line_item it);
            int   s;
            logic lvl;
            logic lp;
            batch.delete();
            items_seen++;
            if (it.mode == MODE_TICK) begin
                // Count down armed timers; expiries are reported in source order.
                for (s = 0; s < NUM_SOURCES; s++) begin
                    if (armed[s]) begin
                        if (count[s] != 0)
                            count[s]--;
                        if (count[s] == 0) begin
                            armed[s] = 1'b0;
                            if (press[s] == PS_PRESSED) begin
                                press[s] = PS_LONG;
                                emit(s, EV_SECONDARY);
                            end
                        end
                    end
                end
            end else if (it.source < NUM_SOURCES) begin
                s   = it.source;
                lvl = it.level ^ invert[s];
                lp  = long_press[s];
                if (button[s]) begin
                    if (lvl) begin
                        // A press only acts from idle; an armed timer keeps its count.
                        if (press[s] == PS_IDLE) begin
                            press[s] = PS_PRESSED;
                            if (lp) begin
                                if (!armed[s]) begin
                                    armed[s] = 1'b1;
                                    count[s] = hold_load();
                                end
                            end else begin
                                emit(s, EV_PRIMARY);
                            end
                        end
                    end else begin
                        // Without long-press the timer is left armed on release.
                        if (lp) begin
                            armed[s] = 1'b0;
                            count[s] = '0;
                            if (press[s] == PS_PRESSED)
                                emit(s, EV_PRIMARY);
                        end else if (press[s] == PS_PRESSED) begin
                            emit(s, EV_SECONDARY);
                        end
                        press[s] = PS_IDLE;
                    end
                end else begin
                    emit(s, lvl);
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[k])
                pending.push_back(batch[k]);
        endfunction

        // Compare a delivered event with the oldest one predicted.
        function void check_event(t_event_rec got);
            t_event_rec want;
            events_seen++;
            if (pending.size() == 0) begin
                $error("unexpected event: event_source %0d event_index %0d last %0d",
                       got.src, got.idx, got.last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.src !== want.src) begin
                $error("event_source: expected %0d, got %0d", want.src, got.src);
                mismatches++;
            end
            if (got.idx !== want.idx) begin
                $error("event_index: expected %0d, got %0d", want.idx, got.idx);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

endpackage

FILE: tb/button_event_classifier_tb.sv
// ----------------------------------------------------------------------------
// Button event classifier testbench
// Drives level changes and ticks through the block under several register
// settings and idle patterns, predicts every event with its own press and
// timer model, and checks the delivered events field by field in order.
// ----------------------------------------------------------------------------
module button_event_classifier_tb;

    import bec_pkg::*;
    import bec_tb_pkg::*;

    // Cycles to let pass after the last event before touching registers.
    localparam int SETTLE_CYCLES = 4 * (1 + NUM_SOURCES);

    // One full register setting.
    typedef struct packed {
        logic [MASK_W-1:0]     inv;
        logic [MASK_W-1:0]     btn;
        logic [MASK_W-1:0]     lp;
        logic [MASK_W-1:0]     ev0;
        logic [MASK_W-1:0]     ev1;
        logic [HOLD_CFG_W-1:0] hold;
    } t_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_mode;
    logic [SRC_W-1:0]      i_source;
    logic                  i_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [SRC_W-1:0]      o_event_source;
    logic                  o_event_index;
    logic                  o_last;

    bec_event_tracker tracker;
    t_setting         cur;
    int               send_idle_pct;
    int               out_stall_pct;
    int               stim_items;
    int               settings_used;

    button_event_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_source       (i_source),
        .i_level        (i_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_source (o_event_source),
        .o_event_index  (o_event_index),
        .o_last         (o_last)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("button_event_classifier: mismatch");
        $finish;
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < out_stall_pct);
    end

    // Check every delivered event.
    always @(posedge i_clk) begin : event_monitor
        t_event_rec seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.src  = o_event_source;
            seen.idx  = o_event_index;
            seen.last = o_last;
            tracker.check_event(seen);
        end
    end

    // Send one item, with random idle cycles ahead of it.
    task automatic send_item(input logic m, input logic [SRC_W-1:0] src, input logic lvl);
        t_line_item it;
        it.mode   = m;
        it.source = src;
        it.level  = lvl;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode     = m;
        i_source   = src;
        i_level    = lvl;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        tracker.note_item(it);
        if (m == MODE_TICK || src < NUM_SOURCES)
            stim_items++;
        @(negedge i_clk);
    endtask

    // A tick with random content in the ignored fields.
    task automatic send_tick();
        send_item(MODE_TICK, SRC_W'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    // Press or release of a source, in terms of the level after inversion.
    task automatic set_line(input int src, input logic active);
        send_item(MODE_LEVEL, SRC_W'(src), active ^ cur.inv[src]);
    endtask

    // Stop sending and wait until every predicted event has arrived.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all registers back to back, plus one write to an unused index.
    task automatic write_setting(input t_setting s);
        logic [CFG_IDX_W-1:0]  idx[7];
        logic [CFG_DATA_W-1:0] val[7];
        for (int k = 0; k < 7; k++)
            val[k] = CFG_DATA_W'($urandom);
        idx[0] = REG_SPARE + CFG_IDX_W'($urandom_range(1));
        idx[1] = REG_INVERT;  val[1][MASK_W-1:0] = s.inv;
        idx[2] = REG_BUTTON;  val[2][MASK_W-1:0] = s.btn;
        idx[3] = REG_LONG;    val[3][MASK_W-1:0] = s.lp;
        idx[4] = REG_EV0_EN;  val[4][MASK_W-1:0] = s.ev0;
        idx[5] = REG_EV1_EN;  val[5][MASK_W-1:0] = s.ev1;
        idx[6] = REG_HOLD;    val[6] = s.hold;
        for (int k = 0; k < 7; k++) begin
            i_cfg_index = idx[k];
            i_cfg_data  = val[k];
            i_cfg_valid = 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            tracker.write_reg(idx[k], val[k]);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
        cur = s;
        settings_used++;
    endtask

    // Press one or two sources, tick a while, then release them.
    task automatic press_hold_release();
        int a;
        int b;
        int span;
        logic two;
        a    = $urandom_range(NUM_SOURCES - 1);
        b    = $urandom_range(NUM_SOURCES - 1);
        two  = 1'($urandom_range(1));
        span = (cur.hold <= 6) ? cur.hold + 2 : 4;
        set_line(a, 1'b1);
        if (two)
            set_line(b, 1'b1);
        repeat ($urandom_range(span)) send_tick();
        if (two && $urandom_range(1)) begin
            set_line(b, 1'b0);
            set_line(a, 1'b0);
        end else begin
            set_line(a, 1'b0);
            if (two)
                set_line(b, 1'b0);
        end
    endtask

    // One random phase under a given setting and idle pattern.
    task automatic run_phase(input t_setting s, input int idle_pct, input int stall_pct,
                             input int n_items);
        int target;
        write_setting(s);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        target = stim_items + n_items;
        while (stim_items < target) begin
            if ($urandom_range(99) < 70)
                press_hold_release();
            else
                send_item(1'($urandom_range(1)), SRC_W'($urandom_range(7)),
                          1'($urandom_range(1)));
        end
        wait_idle();
    endtask

    // Main sequence.
    initial begin
        t_setting s;
        int       idle_pcts[4];
        int       stall_pcts[4];
        idle_pcts  = '{0, 48, 0, 25};
        stall_pcts = '{0, 0, 48, 25};
        tracker       = new();
        stim_items    = 0;
        settings_used = 0;
        send_idle_pct = 0;
        out_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_LEVEL;
        i_source    = '0;
        i_level     = 1'b0;
        i_out_stall = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: long-press buttons 0 and 1, plain button 2 inverted,
        // plain lines 3 and 4, every event enabled, zero hold length.
        s = '{inv: 5'b00100, btn: 5'b00111, lp: 5'b00011,
              ev0: 5'b11111, ev1: 5'b11111, hold: 16'd0};
        write_setting(s);
        send_item(MODE_LEVEL, 3'd0, 1'b1);   // arms a one-tick timer
        send_item(MODE_TICK,  3'd0, 1'b0);   // expiry: long press
        send_item(MODE_LEVEL, 3'd0, 1'b0);   // release after long press
        send_item(MODE_LEVEL, 3'd1, 1'b1);
        send_item(MODE_LEVEL, 3'd1, 1'b1);   // press while already pressed
        send_item(MODE_LEVEL, 3'd1, 1'b0);   // short click
        send_item(MODE_LEVEL, 3'd2, 1'b0);   // inverted press
        send_item(MODE_LEVEL, 3'd2, 1'b1);   // inverted release
        send_item(MODE_LEVEL, 3'd3, 1'b1);
        send_item(MODE_LEVEL, 3'd3, 1'b0);
        send_item(MODE_LEVEL, 3'd4, 1'b0);
        send_item(MODE_LEVEL, 3'd4, 1'b1);
        send_item(MODE_LEVEL, 3'd5, 1'b1);   // out of range sources
        send_item(MODE_LEVEL, 3'd7, 1'b0);
        send_item(MODE_TICK,  3'd6, 1'b1);   // nothing armed
        wait_idle();

        // Directed: long-press turned off while held, a press on a still-armed
        // timer, and two timers expiring on the same tick.
        s.hold = 16'd3;
        write_setting(s);
        send_item(MODE_LEVEL, 3'd0, 1'b1);
        send_item(MODE_LEVEL, 3'd1, 1'b1);
        send_item(MODE_TICK,  3'd0, 1'b0);
        wait_idle();
        s.lp = 5'b00000;
        write_setting(s);
        send_item(MODE_LEVEL, 3'd0, 1'b0);   // release leaves the timer armed
        wait_idle();
        s.lp = 5'b00011;
        write_setting(s);
        send_item(MODE_LEVEL, 3'd0, 1'b1);   // timer already armed
        send_item(MODE_TICK,  3'd1, 1'b1);
        send_item(MODE_TICK,  3'd2, 1'b0);   // both timers expire
        send_item(MODE_LEVEL, 3'd0, 1'b0);
        send_item(MODE_LEVEL, 3'd1, 1'b0);
        wait_idle();

        // Random phases, one setting each, cycling through the idle patterns.
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                s = '{inv: 5'($urandom), btn: 5'b11111, lp: 5'b11111,
                      ev0: 5'b11111, ev1: 5'b11111, hold: 16'd0};
            end else if (p == 1) begin
                s = '{inv: 5'b00000, btn: 5'b00000, lp: 5'b00000,
                      ev0: 5'b00000, ev1: 5'b00000, hold: 16'hFFFF};
            end else if (p == 2) begin
                s = '{inv: 5'($urandom), btn: 5'b11111, lp: 5'b11111,
                      ev0: 5'b11111, ev1: 5'b11111, hold: 16'hFFFF};
            end else begin
                s = '{inv: 5'($urandom), btn: 5'($urandom), lp: 5'($urandom),
                      ev0: 5'($urandom), ev1: 5'($urandom),
                      hold: 16'($urandom_range(6))};
            end
            run_phase(s, idle_pcts[p % 4], stall_pcts[p % 4], 10);
        end

        $display("Checked %0d events from %0d accepted items over %0d register settings,",
                 tracker.events_seen, tracker.items_seen, settings_used);
        $display("with the sender and receiver idling in four patterns.");
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("button_event_classifier: match");
        end else begin
            $display("button_event_classifier: mismatch");
        end
        $finish;
    end

endmodule
